### hw/rtl/rat_pkg.sv
`default_nettype none

package rat_pkg;

    // Number of minima captured before the run ends.
    localparam int unsigned PEAK_COUNT = 8;
    localparam int unsigned CNT_W      = $clog2(PEAK_COUNT + 1);

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned STEP_W     = 15;
    localparam int unsigned HYST_W     = 16;
    localparam int unsigned DRIVE_W    = 16;
    localparam int unsigned PERIOD_W   = 39;
    localparam int unsigned AMP_W      = 40;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT    = 2'd0,
        CFG_OUTPUT_STEP = 2'd1,
        CFG_HYSTERESIS  = 2'd2
    } cfg_index_t;

    typedef enum logic [0:0] {
        ACT_START  = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_MAX  = 2'd1,
        EV_MIN  = 2'd2
    } event_t;

    typedef struct packed {
        logic [DATA_W-1:0] setpoint;
        logic [STEP_W-1:0] output_step;
        logic [HYST_W-1:0] hysteresis;
    } cfg_t;

    typedef struct packed {
        action_t                  action;
        logic signed [DATA_W-1:0] sample;
        logic [DATA_W-1:0]        timestamp_us;
    } in_beat_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      done_res;
        event_t                    event_res;
        logic signed [DATA_W-1:0]  peak_value;
        logic [DATA_W-1:0]         peak_time;
        logic [PERIOD_W-1:0]       period_sum;
        logic signed [AMP_W-1:0]   amplitude_sum;
    } out_beat_t;

endpackage

`default_nettype wire

### hw/rtl/rat_core.sv
`default_nettype none

module rat_core
    import rat_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_fire,
    input  wire in_beat_t  in_beat,
    input  wire cfg_t      cfg,
    output out_beat_t      result
);

    logic                      running_reg, running_next;
    logic                      above_reg, above_next;
    logic                      first_reg, first_next;
    logic                      finished_reg, finished_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic signed [DATA_W-1:0]  cand_val_reg, cand_val_next;
    logic [DATA_W-1:0]         cand_time_reg, cand_time_next;
    logic [DATA_W-1:0]         last_max_reg, last_max_next;
    logic [DATA_W-1:0]         last_min_reg, last_min_next;
    logic                      max_seen_reg, max_seen_next;
    logic [CNT_W-1:0]          min_count_reg, min_count_next;
    logic [PERIOD_W-1:0]       period_reg, period_next;
    logic signed [AMP_W-1:0]   amp_reg, amp_next;
    event_t                    event_c;

    logic signed [DATA_W:0]    sample_x;
    logic signed [DATA_W:0]    thr_hi;
    logic signed [DATA_W:0]    thr_lo;
    logic signed [DATA_W:0]    half_x;
    logic signed [DRIVE_W-1:0] step_pos;
    logic [DATA_W-1:0]         period_inc;
    logic [DATA_W-1:0]         period_base;

    assign sample_x = {in_beat.sample[DATA_W-1], in_beat.sample};
    assign half_x   = {{(DATA_W+1-(HYST_W-1)){1'b0}}, cfg.hysteresis[HYST_W-1:1]};
    assign thr_hi   = {cfg.setpoint[DATA_W-1], cfg.setpoint} + half_x;
    assign thr_lo   = {cfg.setpoint[DATA_W-1], cfg.setpoint} - half_x;
    assign step_pos = {{(DRIVE_W-STEP_W){1'b0}}, cfg.output_step};
    assign period_base = above_reg ? last_max_reg : last_min_reg;
    assign period_inc  = cand_time_next - period_base;

    always_comb begin
        running_next   = running_reg;
        above_next     = above_reg;
        first_next     = first_reg;
        finished_next  = finished_reg;
        drive_next     = drive_reg;
        cand_val_next  = cand_val_reg;
        cand_time_next = cand_time_reg;
        last_max_next  = last_max_reg;
        last_min_next  = last_min_reg;
        max_seen_next  = max_seen_reg;
        min_count_next = min_count_reg;
        period_next    = period_reg;
        amp_next       = amp_reg;
        event_c        = EV_NONE;

        if (in_beat.action == ACT_START) begin
            running_next   = 1'b1;
            finished_next  = 1'b0;
            above_next     = 1'b0;
            first_next     = 1'b1;
            cand_val_next  = cfg.setpoint;
            cand_time_next = '0;
            last_max_next  = '0;
            last_min_next  = '0;
            max_seen_next  = 1'b0;
            min_count_next = '0;
            period_next    = '0;
            amp_next       = '0;
            drive_next     = step_pos;
        end else if (running_reg && !finished_reg) begin
            if (!above_reg) begin
                if (in_beat.sample < cand_val_reg) begin
                    cand_val_next  = in_beat.sample;
                    cand_time_next = in_beat.timestamp_us;
                end
                if (sample_x > thr_hi) begin
                    // The minimum before the first upward crossing is not a real peak.
                    if (!first_reg) begin
                        if (min_count_reg != '0) begin
                            period_next = period_reg
                                + {{(PERIOD_W-DATA_W){1'b0}}, period_inc};
                            amp_next = amp_reg
                                - {{(AMP_W-DATA_W){cand_val_next[DATA_W-1]}}, cand_val_next};
                        end
                        last_min_next  = cand_time_next;
                        min_count_next = min_count_reg + 1'b1;
                        event_c        = EV_MIN;
                    end
                    first_next = 1'b0;
                    drive_next = -step_pos;
                    above_next = 1'b1;
                end
            end else begin
                if (in_beat.sample > cand_val_reg) begin
                    cand_val_next  = in_beat.sample;
                    cand_time_next = in_beat.timestamp_us;
                end
                if (sample_x < thr_lo) begin
                    if (max_seen_reg) begin
                        period_next = period_reg
                            + {{(PERIOD_W-DATA_W){1'b0}}, period_inc};
                        amp_next = amp_reg
                            + {{(AMP_W-DATA_W){cand_val_next[DATA_W-1]}}, cand_val_next};
                    end
                    last_max_next = cand_time_next;
                    max_seen_next = 1'b1;
                    event_c       = EV_MAX;
                    drive_next    = step_pos;
                    above_next    = 1'b0;
                end
            end
            if (min_count_next == CNT_W'(PEAK_COUNT)) begin
                finished_next = 1'b1;
                drive_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg   <= 1'b0;
            above_reg     <= 1'b0;
            first_reg     <= 1'b1;
            finished_reg  <= 1'b0;
            drive_reg     <= '0;
            cand_val_reg  <= '0;
            cand_time_reg <= '0;
            last_max_reg  <= '0;
            last_min_reg  <= '0;
            max_seen_reg  <= 1'b0;
            min_count_reg <= '0;
            period_reg    <= '0;
            amp_reg       <= '0;
        end else if (in_fire) begin
            running_reg   <= running_next;
            above_reg     <= above_next;
            first_reg     <= first_next;
            finished_reg  <= finished_next;
            drive_reg     <= drive_next;
            cand_val_reg  <= cand_val_next;
            cand_time_reg <= cand_time_next;
            last_max_reg  <= last_max_next;
            last_min_reg  <= last_min_next;
            max_seen_reg  <= max_seen_next;
            min_count_reg <= min_count_next;
            period_reg    <= period_next;
            amp_reg       <= amp_next;
        end
    end

    always_comb begin
        result.drive         = drive_next;
        result.done_res      = finished_next;
        result.event_res     = event_c;
        result.peak_value    = cand_val_next;
        result.peak_time     = cand_time_next;
        result.period_sum    = period_next;
        result.amplitude_sum = amp_next;
    end

endmodule

`default_nettype wire

### hw/rtl/relay_autotune_peak_capture.sv
// Relay autotune peak capture. Configure setpoint, output_step and hysteresis
// through the write port while idle, send a start beat (action 0), then one
// sample beat per measurement. Every input beat produces exactly one result
// beat carrying the relay drive to apply, the peak just recorded (event 1 for
// a maximum, 2 for a minimum) and the running period and amplitude sums.
// The block takes one beat per clock: the whole update is combinational logic
// from the state registers into a result register, and a two-entry output
// buffer (result register plus skid register) lets input flow while a result
// waits, so s_ready drops only when both are full. After PEAK_COUNT minima the
// drive reads zero and samples are ignored until the next start beat.
`default_nettype none

module relay_autotune_peak_capture
    import rat_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_beat_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_beat_t                 m_data
);

    cfg_t      cfg_reg;
    out_beat_t result;
    out_beat_t out_data_reg;
    out_beat_t skid_data_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      in_fire;
    logic      out_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SETPOINT:    cfg_reg.setpoint    <= cfg_wdata;
                CFG_OUTPUT_STEP: cfg_reg.output_step <= cfg_wdata[STEP_W-1:0];
                CFG_HYSTERESIS:  cfg_reg.hysteresis  <= cfg_wdata[HYST_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;

    rat_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_beat (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    // A waiting skid beat always moves up before a new result can enter.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_fire) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (in_fire) begin
            if (out_valid_reg && !m_ready) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
